// File: hw/rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared constants and types of the burst period meter.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int MAX_WINDOW   = 256;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = CH_W + 1;
    localparam int POS_W        = $clog2(MAX_WINDOW);
    localparam int WIN_W        = POS_W + 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_W        = 64;
    localparam int DVS_W        = 33;
    localparam int MEAN_W       = 48;

    localparam logic [CFG_IDX_W-1:0] REG_NEURON_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

    typedef struct packed {
        logic [15:0] level;
        logic [31:0] prev_fall;
        logic [31:0] fall;
        logic [31:0] rise;
        logic [31:0] period;
        logic [31:0] active;
    } chan_entry_t;

    typedef struct packed {
        logic              en;
        logic [CH_W-1:0]   addr;
        chan_entry_t       data;
    } chan_wr_t;

    typedef struct packed {
        logic              en;
        logic [POS_W-1:0]  addr;
        logic [MEAN_W-1:0] period;
        logic [MEAN_W-1:0] active;
    } ring_wr_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

endpackage

// File: hw/rtl/bpm_if.sv
// ----------------------------------------------------------------------------
// bpm_in_if / bpm_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface bpm_in_if;
    logic        valid;
    logic        ready;
    logic [5:0]  channel;
    logic [15:0] activation;
    logic [31:0] tick_time;
    logic        last_channel;

    modport source (output valid, channel, activation, tick_time, last_channel,
                    input ready);
    modport sink (input valid, channel, activation, tick_time, last_channel,
                  output ready);
endinterface

interface bpm_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] mean_period;
    logic [47:0] mean_active;

    modport source (output valid, mean_period, mean_active, input ready);
    modport sink (input valid, mean_period, mean_active, output ready);
endinterface

// File: hw/rtl/bpm_chan_mem.sv
// ----------------------------------------------------------------------------
// bpm_chan_mem
// Per-channel state RAM, registered read, valid bit per entry.
// ----------------------------------------------------------------------------
module bpm_chan_mem import bpm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rd_en,
    input  logic [CH_W-1:0] rd_addr,
    input  chan_wr_t        wr,
    output chan_entry_t     rd_data
);

    chan_entry_t                ram [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]    vld_reg;
    chan_entry_t                data_reg;
    logic                       hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ram[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            data_reg <= ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as reset value
    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// File: hw/rtl/bpm_ring_mem.sv
// ----------------------------------------------------------------------------
// bpm_ring_mem
// History ring RAM for the windowed mean, registered read, valid per entry.
// ----------------------------------------------------------------------------
module bpm_ring_mem import bpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [POS_W-1:0]   rd_addr,
    input  ring_wr_t           wr,
    output logic [MEAN_W-1:0]  rd_period,
    output logic [MEAN_W-1:0]  rd_active
);

    logic [2*MEAN_W-1:0]     ram [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   vld_reg;
    logic [2*MEAN_W-1:0]     data_reg;
    logic                    hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ram[wr.addr] <= {wr.period, wr.active};
        end
        if (rd_en)
        begin
            data_reg <= ram[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_period = hit_reg ? data_reg[2*MEAN_W-1:MEAN_W] : '0;
    assign rd_active = hit_reg ? data_reg[MEAN_W-1:0] : '0;

endmodule

// File: hw/rtl/bpm_div.sv
// ----------------------------------------------------------------------------
// bpm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpm_div import bpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_req_t          req,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    localparam int STEP_W = $clog2(DIV_W) + 1;

    logic [DIV_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              take;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign take  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                quo_reg  <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                cnt_reg  <= STEP_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], take};
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/multichannel_burst_period_meter_unit.sv
// ----------------------------------------------------------------------------
// multichannel_burst_period_meter_unit
// Per-channel crossing timer with tick-end averaging and mean tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one channel sample per item (channel, activation, tick_time,
//   last_channel). out_ch delivers one item (mean_period, mean_active, Q32.16)
//   for each input item marked last_channel.
//   A sample takes one read and one write-back of the channel RAM.
//   A tick-end item then sweeps channels 1 to n-1 with a read and a write-back
//   of each, makes four passes of the shared 64-step divider, and in windowed
//   mode sums the window's entries of the ring RAM. The divider and the
//   single RAM ports set this cost.
//   in_ch is ready only between items; a result waits in the output register
//   while the next samples are taken, and a following tick end holds until
//   the receiver has taken it.
//   Reset clears all state at once (valid bits on both RAMs), registers take
//   neuron_count 2, threshold 3277, window_length 0. Configuration writes go through
//   cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not check.
// ----------------------------------------------------------------------------
module multichannel_burst_period_meter_unit import bpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    bpm_in_if.sink                in_ch,
    bpm_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SAMPLE, ST_SW_RD, ST_SW_WR, ST_DIV_GO, ST_DIV_WAIT,
        ST_RING_WR, ST_RG_RD, ST_RG_ACC, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_TM_P, OP_TM_A, OP_RUN_P, OP_RUN_A, OP_RING_P, OP_RING_A
    } op_t;

    state_t             state_reg;
    op_t                op_reg;
    logic [6:0]         count_cfg_reg;
    logic [15:0]        thr_reg;
    logic [8:0]         win_cfg_reg;

    logic [CH_W-1:0]    ch_reg;
    logic [15:0]        act_reg;
    logic [31:0]        t_reg;
    logic               last_reg;
    logic               hit_reg;
    logic [CH_W-1:0]    idx_reg;
    logic [39:0]        sum_p_reg;
    logic [39:0]        sum_a_reg;
    logic [55:0]        tm_p_reg;
    logic [55:0]        tm_a_reg;
    logic [MEAN_W-1:0]  mean_p_reg;
    logic [MEAN_W-1:0]  mean_a_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   rj_reg;
    logic [55:0]        rsum_p_reg;
    logic [55:0]        rsum_a_reg;
    logic               out_valid_reg;
    logic [MEAN_W-1:0]  out_p_reg;
    logic [MEAN_W-1:0]  out_a_reg;

    logic [CNT_W-1:0]   n_eff;
    logic [WIN_W-1:0]   w_eff;
    logic               in_hit;
    logic               ring_mode;
    logic               accept;
    logic               out_load;

    chan_entry_t        c_rd;
    chan_wr_t           c_wr;
    logic               c_rd_en;
    logic [CH_W-1:0]    c_rd_addr;
    logic [MEAN_W-1:0]  r_rd_p;
    logic [MEAN_W-1:0]  r_rd_a;
    ring_wr_t           r_wr;
    logic [POS_W-1:0]   pos_new;
    div_req_t           dreq;
    logic               div_busy;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    chan_entry_t        samp_e;
    chan_entry_t        sw_e;
    logic               fall;
    logic               rise;
    logic [55:0]        run_x;
    logic [55:0]        run_old;
    logic               run_ge;
    logic [32:0]        run_d;
    logic [55:0]        run_res;

    assign n_eff = (count_cfg_reg < 7'd2) ? CNT_W'(2) :
                   (count_cfg_reg > 7'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) :
                   CNT_W'(count_cfg_reg);
    assign w_eff = (win_cfg_reg > 9'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : WIN_W'(win_cfg_reg);
    assign ring_mode = w_eff != '0;
    assign in_hit = (in_ch.channel != 6'd0) && ({1'b0, in_ch.channel} < n_eff);
    assign in_ch.ready = state_reg == ST_IDLE;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    // channel RAM port
    assign c_rd_en   = accept || (state_reg == ST_SW_RD);
    assign c_rd_addr = accept ? in_ch.channel : idx_reg;

    // crossing detection; whether a level equal to the threshold counts as high follows the mode
    always_comb
    begin
        if (ring_mode)
        begin
            fall = (c_rd.level > thr_reg) && (act_reg <= thr_reg);
            rise = (c_rd.level <= thr_reg) && (act_reg > thr_reg);
        end
        else
        begin
            fall = (c_rd.level >= thr_reg) && (act_reg < thr_reg);
            rise = (c_rd.level < thr_reg) && (act_reg >= thr_reg);
        end
        samp_e = c_rd;
        samp_e.level = act_reg;
        if (fall)
        begin
            samp_e.fall = t_reg;
        end
        if (rise)
        begin
            samp_e.rise = t_reg;
        end
        sw_e = c_rd;
        if (c_rd.fall != c_rd.prev_fall)
        begin
            sw_e.period = c_rd.fall - c_rd.prev_fall;
            sw_e.active = c_rd.fall - c_rd.rise;
        end
        sw_e.prev_fall = c_rd.fall;
    end

    always_comb
    begin
        c_wr = '0;
        if (state_reg == ST_SAMPLE && hit_reg)
        begin
            c_wr.en   = 1'b1;
            c_wr.addr = ch_reg;
            c_wr.data = samp_e;
        end
        else if (state_reg == ST_SW_WR)
        begin
            c_wr.en   = 1'b1;
            c_wr.addr = idx_reg;
            c_wr.data = sw_e;
        end
    end

    // ring RAM: advance then write the tick mean
    assign pos_new = ({1'b0, pos_reg} >= (w_eff - WIN_W'(1))) ? '0 : pos_reg + POS_W'(1);
    always_comb
    begin
        r_wr        = '0;
        r_wr.en     = state_reg == ST_RING_WR;
        r_wr.addr   = pos_new;
        r_wr.period = tm_p_reg[MEAN_W-1:0];
        r_wr.active = tm_a_reg[MEAN_W-1:0];
    end

    // running mean: old + (x-old)/d, or old - ceil((old-x)/d)
    assign run_x   = (op_reg == OP_RUN_P) ? tm_p_reg : tm_a_reg;
    assign run_old = (op_reg == OP_RUN_P) ? 56'(mean_p_reg) : 56'(mean_a_reg);
    assign run_ge  = run_x >= run_old;
    assign run_d   = {1'b0, t_reg} + 33'd1;
    assign run_res = run_ge ? run_old + div_q[55:0] : run_old - div_q[55:0];

    always_comb
    begin
        dreq = '0;
        dreq.start = state_reg == ST_DIV_GO;
        case (op_reg)
            OP_TM_P:
            begin
                dreq.dividend = {8'b0, sum_p_reg, 16'b0};
                dreq.divisor  = 33'(n_eff - CNT_W'(1));
            end
            OP_TM_A:
            begin
                dreq.dividend = {8'b0, sum_a_reg, 16'b0};
                dreq.divisor  = 33'(n_eff - CNT_W'(1));
            end
            OP_RUN_P, OP_RUN_A:
            begin
                dreq.dividend = run_ge ? {8'b0, run_x - run_old} :
                                {8'b0, run_old - run_x} + 64'(run_d) - 64'd1;
                dreq.divisor  = run_d;
            end
            OP_RING_P:
            begin
                dreq.dividend = {8'b0, rsum_p_reg};
                dreq.divisor  = 33'(w_eff);
            end
            OP_RING_A:
            begin
                dreq.dividend = {8'b0, rsum_a_reg};
                dreq.divisor  = 33'(w_eff);
            end
            default:
            begin
                dreq.dividend = '0;
                dreq.divisor  = 33'd1;
            end
        endcase
    end

    bpm_chan_mem u_chan_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (c_rd_en),
        .rd_addr (c_rd_addr),
        .wr      (c_wr),
        .rd_data (c_rd)
    );

    bpm_ring_mem u_ring_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (state_reg == ST_RG_RD),
        .rd_addr   (rj_reg),
        .wr        (r_wr),
        .rd_period (r_rd_p),
        .rd_active (r_rd_a)
    );

    bpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_TM_P;
            count_cfg_reg <= 7'd2;
            thr_reg       <= 16'd3277;
            win_cfg_reg   <= 9'd0;
            ch_reg        <= '0;
            act_reg       <= '0;
            t_reg         <= '0;
            last_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            idx_reg       <= '0;
            sum_p_reg     <= '0;
            sum_a_reg     <= '0;
            tm_p_reg      <= '0;
            tm_a_reg      <= '0;
            mean_p_reg    <= '0;
            mean_a_reg    <= '0;
            pos_reg       <= '0;
            rj_reg        <= '0;
            rsum_p_reg    <= '0;
            rsum_a_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_p_reg     <= '0;
            out_a_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NEURON_COUNT:  count_cfg_reg <= cfg_data[6:0];
                    REG_THRESHOLD:     thr_reg       <= cfg_data;
                    REG_WINDOW_LENGTH: win_cfg_reg   <= cfg_data[8:0];
                    default: ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg    <= in_ch.channel;
                        act_reg   <= in_ch.activation;
                        t_reg     <= in_ch.tick_time;
                        last_reg  <= in_ch.last_channel;
                        hit_reg   <= in_hit;
                        state_reg <= ST_SAMPLE;
                    end
                end
                ST_SAMPLE:
                begin
                    if (last_reg)
                    begin
                        idx_reg   <= CH_W'(1);
                        sum_p_reg <= '0;
                        sum_a_reg <= '0;
                        state_reg <= ST_SW_RD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SW_RD:
                begin
                    state_reg <= ST_SW_WR;
                end
                ST_SW_WR:
                begin
                    sum_p_reg <= sum_p_reg + 40'(sw_e.period);
                    sum_a_reg <= sum_a_reg + 40'(sw_e.active);
                    idx_reg   <= idx_reg + CH_W'(1);
                    if ({1'b0, idx_reg} + CNT_W'(1) == n_eff)
                    begin
                        op_reg    <= OP_TM_P;
                        state_reg <= ST_DIV_GO;
                    end
                    else
                    begin
                        state_reg <= ST_SW_RD;
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        case (op_reg)
                            OP_TM_P:
                            begin
                                tm_p_reg  <= div_q[55:0];
                                op_reg    <= OP_TM_A;
                                state_reg <= ST_DIV_GO;
                            end
                            OP_TM_A:
                            begin
                                tm_a_reg <= div_q[55:0];
                                if (ring_mode)
                                begin
                                    state_reg <= ST_RING_WR;
                                end
                                else
                                begin
                                    op_reg    <= OP_RUN_P;
                                    state_reg <= ST_DIV_GO;
                                end
                            end
                            OP_RUN_P:
                            begin
                                mean_p_reg <= run_res[MEAN_W-1:0];
                                op_reg     <= OP_RUN_A;
                                state_reg  <= ST_DIV_GO;
                            end
                            OP_RUN_A:
                            begin
                                mean_a_reg <= run_res[MEAN_W-1:0];
                                state_reg  <= ST_DONE;
                            end
                            OP_RING_P:
                            begin
                                mean_p_reg <= div_q[MEAN_W-1:0];
                                op_reg     <= OP_RING_A;
                                state_reg  <= ST_DIV_GO;
                            end
                            OP_RING_A:
                            begin
                                mean_a_reg <= div_q[MEAN_W-1:0];
                                state_reg  <= ST_DONE;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RING_WR:
                begin
                    pos_reg    <= pos_new;
                    rj_reg     <= '0;
                    rsum_p_reg <= '0;
                    rsum_a_reg <= '0;
                    state_reg  <= ST_RG_RD;
                end
                ST_RG_RD:
                begin
                    state_reg <= ST_RG_ACC;
                end
                ST_RG_ACC:
                begin
                    rsum_p_reg <= rsum_p_reg + 56'(r_rd_p);
                    rsum_a_reg <= rsum_a_reg + 56'(r_rd_a);
                    rj_reg     <= rj_reg + POS_W'(1);
                    if ({1'b0, rj_reg} + WIN_W'(1) == w_eff)
                    begin
                        op_reg    <= OP_RING_P;
                        state_reg <= ST_DIV_GO;
                    end
                    else
                    begin
                        state_reg <= ST_RG_RD;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        out_p_reg     <= mean_p_reg;
                        out_a_reg     <= mean_a_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.mean_period = out_p_reg;
    assign out_ch.mean_active = out_a_reg;

    // channel zero is never written
    a_no_ch0_write: assert property (@(posedge clk) disable iff (!rst_n)
        c_wr.en |-> c_wr.addr != '0)
        else $error("write to channel zero");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !div_busy)
        else $error("divider started while busy");

    a_ring_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        r_wr.en |-> ({1'b0, r_wr.addr} < w_eff))
        else $error("ring write outside window");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && (!out_valid_reg || out_ch.ready)) |=>
        (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded");

endmodule
